/* rtl/core/tiu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tiu_pkg;

    localparam int DATA_W             = 16;
    localparam int PCOUNT_W           = 5;
    localparam int ENTRY_INDEX_W      = 4;
    localparam int DEFAULT_MAX_POINTS = 16;
    localparam int S_TDATA_W          = 56;

    localparam logic [DATA_W-1:0] FULL_SCALE = 16'hFFFF;

    localparam logic ACTION_WRITE  = 1'b0;
    localparam logic ACTION_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOP,
        ST_LOW,
        ST_SEARCH,
        ST_START,
        ST_WAIT,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_DIV,
        MD_MUL,
        MD_SCALE
    } md_state_t;

    // request to the serial divide/multiply unit
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dx;
        logic [DATA_W-1:0] dd;
        logic [DATA_W-1:0] dy;
    } md_req_t;

endpackage

`default_nettype wire

/* rtl/core/tiu_muldiv.sv */
`timescale 1ns / 1ps
`default_nettype none

module tiu_muldiv
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tiu_pkg::md_req_t            req,
    output logic                             done,
    output logic [tiu_pkg::DATA_W-1:0]       d
);
    import tiu_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    md_state_t             md_state_reg, md_state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [2*DATA_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]     opnd_reg, opnd_next;
    logic [DATA_W-1:0]     dy_reg, dy_next;
    logic [DATA_W-1:0]     d_reg, d_next;
    logic                  done_reg, done_next;

    logic                  last_step;
    logic [DATA_W:0]       div_try;
    logic                  div_ge;
    logic [DATA_W:0]       div_r;
    logic [DATA_W-1:0]     quot;
    logic [DATA_W:0]       mul_sum;
    logic [DATA_W:0]       scale_s;
    logic [DATA_W-1:0]     scale_c;

    assign last_step = (cnt_reg == {CNT_W{1'b1}});

    // restoring divide step
    assign div_try = {acc_reg[2*DATA_W-1:DATA_W], acc_reg[DATA_W-1]};
    assign div_ge  = (div_try >= {1'b0, opnd_reg});
    assign div_r   = div_ge ? (div_try - {1'b0, opnd_reg}) : div_try;
    assign quot    = {acc_reg[DATA_W-2:0], div_ge};

    // shift-add multiply step
    assign mul_sum = {1'b0, acc_reg[2*DATA_W-1:DATA_W]}
                   + (acc_reg[0] ? {1'b0, opnd_reg} : '0);

    // product / full scale: hi + (hi + lo) / full scale, the second term below 3
    assign scale_s = {1'b0, acc_reg[2*DATA_W-1:DATA_W]} + {1'b0, acc_reg[DATA_W-1:0]};
    always_comb
    begin
        priority if (scale_s >= {FULL_SCALE, 1'b0})
        begin
            scale_c = DATA_W'(2);
        end
        else if (scale_s >= {1'b0, FULL_SCALE})
        begin
            scale_c = DATA_W'(1);
        end
        else
        begin
            scale_c = '0;
        end
    end

    always_comb
    begin
        md_state_next = md_state_reg;
        unique case (md_state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    md_state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                if (last_step)
                begin
                    md_state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                if (last_step)
                begin
                    md_state_next = MD_SCALE;
                end
            end
            MD_SCALE:
            begin
                md_state_next = MD_IDLE;
            end
            default:
            begin
                md_state_next = MD_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        opnd_next = opnd_reg;
        dy_next   = dy_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        unique case (md_state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    // numerator = full scale * dx
                    acc_next  = {req.dx, {DATA_W{1'b0}}} - {{DATA_W{1'b0}}, req.dx};
                    opnd_next = req.dd;
                    dy_next   = req.dy;
                    cnt_next  = '0;
                end
            end
            MD_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    opnd_next = quot + DATA_W'(1);
                    acc_next  = {{DATA_W{1'b0}}, dy_reg};
                end
                else
                begin
                    acc_next = {div_r[DATA_W-1:0], quot};
                end
            end
            MD_MUL:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                acc_next = {mul_sum, acc_reg[DATA_W-1:1]};
            end
            MD_SCALE:
            begin
                d_next    = acc_reg[2*DATA_W-1:DATA_W] + scale_c;
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            md_state_reg <= MD_IDLE;
            cnt_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            md_state_reg <= md_state_next;
            cnt_reg      <= cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        opnd_reg <= opnd_next;
        dy_reg   <= dy_next;
        d_reg    <= d_next;
    end

    assign done = done_reg;
    assign d    = d_reg;

endmodule

`default_nettype wire

/* rtl/core/table_interp_unsigned.sv */
`timescale 1ns / 1ps
`default_nettype none

// piecewise-linear lookup over a table of 16-bit (x, y) breakpoints
// input stream s_axis: tuser selects write (load one breakpoint) or lookup;
// a write item gives no output item, a lookup gives exactly one on m_axis
// cfg_wr_en / cfg_wr_data set the number of breakpoints in use
// one item is worked on at a time; s_axis_tready is high only while idle
// a write is done once accepted; a lookup with zero points goes straight to
// its result, a clamped lookup after reading the top and, if x lies below
// it, the bottom breakpoint; an interpolated lookup searches down for its
// segment, visiting 1 to points - 1 breakpoints, then runs the 16-step
// serial divider and the 16-step serial multiplier
// the next item is taken as soon as the result sits in the output register,
// even if the receiver has not yet taken it; a stalled m_axis holds the
// result and the next lookup waits before handing over its own
// reset clears the point count and control state; the table is not cleared
// and must be written before it is looked up
module table_interp_unsigned
#(
    parameter int MAX_POINTS = tiu_pkg::DEFAULT_MAX_POINTS
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tiu_pkg::PCOUNT_W-1:0]   cfg_wr_data,   // point_count
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index[3:0], entry_x[19:4], entry_y[35:20], x_value[51:36], zeros
    input  wire logic [tiu_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                           s_axis_tuser,  // action
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [tiu_pkg::DATA_W-1:0]          m_axis_tdata   // y_value
);
    import tiu_pkg::*;

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef struct packed {
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] x;
    } bp_entry_t;

    bp_entry_t             mem [MAX_POINTS];
    bp_entry_t             rd_data_reg;
    logic [IW-1:0]         rd_addr;
    logic                  mem_we;

    logic [PCOUNT_W-1:0]   point_count_reg;

    state_t                state_reg, state_next;
    logic [IW-1:0]         hi_reg, hi_next;
    logic [DATA_W-1:0]     x_reg, x_next;
    logic [DATA_W-1:0]     x0_reg, x0_next;
    logic [DATA_W-1:0]     y0_reg, y0_next;
    logic [DATA_W-1:0]     x1_reg, x1_next;
    logic [DATA_W-1:0]     y1_reg, y1_next;
    logic [DATA_W-1:0]     res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]     out_data_reg, out_data_next;

    logic [ENTRY_INDEX_W-1:0] in_index;
    logic [DATA_W-1:0]     in_entry_x;
    logic [DATA_W-1:0]     in_entry_y;
    logic [DATA_W-1:0]     in_x_value;
    logic                  in_accept;
    logic                  count_clamped;
    logic                  count_zero;
    logic [IW-1:0]         hi_top;
    logic                  index_ok;
    logic                  at_or_above;
    logic                  at_or_below;
    logic                  step_down;
    logic                  rising;
    logic                  out_free;

    md_req_t               md_req;
    logic                  md_done;
    logic [DATA_W-1:0]     md_d;

    assign in_index   = s_axis_tdata[ENTRY_INDEX_W-1:0];
    assign in_entry_x = s_axis_tdata[ENTRY_INDEX_W+DATA_W-1:ENTRY_INDEX_W];
    assign in_entry_y = s_axis_tdata[ENTRY_INDEX_W+2*DATA_W-1:ENTRY_INDEX_W+DATA_W];
    assign in_x_value = s_axis_tdata[ENTRY_INDEX_W+3*DATA_W-1:ENTRY_INDEX_W+2*DATA_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // point count above capacity acts as a full table
    assign count_clamped = (32'(point_count_reg) > 32'(MAX_POINTS));
    assign count_zero    = (point_count_reg == '0);
    assign hi_top        = count_clamped ? IW'(MAX_POINTS - 1)
                                         : IW'(32'(point_count_reg) - 32'd1);
    assign index_ok      = (32'(in_index) < 32'(MAX_POINTS));

    assign mem_we      = in_accept && (s_axis_tuser == ACTION_WRITE) && index_ok;
    assign at_or_above = (x_reg >= rd_data_reg.x);
    assign at_or_below = (x_reg <= rd_data_reg.x);
    assign step_down   = (hi_reg > IW'(1)) && (rd_data_reg.x > x_reg);
    assign rising      = (y0_reg < y1_reg);
    assign out_free    = !out_valid_reg || m_axis_tready;

    assign md_req.start = (state_reg == ST_START);
    assign md_req.dx    = x_reg - x0_reg;
    assign md_req.dd    = x1_reg - x0_reg;
    assign md_req.dy    = rising ? (y1_reg - y0_reg) : (y0_reg - y1_reg);

    tiu_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .done  (md_done),
        .d     (md_d)
    );

    // breakpoint table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[IW'(in_index)] <= '{y: in_entry_y, x: in_entry_x};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:   rd_addr = hi_top;
            ST_TOP:    rd_addr = '0;
            ST_LOW:    rd_addr = hi_reg - IW'(1);
            ST_SEARCH: rd_addr = hi_reg - IW'(2);
            default:   rd_addr = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_axis_tuser == ACTION_LOOKUP))
                begin
                    state_next = count_zero ? ST_RESULT : ST_TOP;
                end
            end
            ST_TOP:
            begin
                state_next = at_or_above ? ST_RESULT : ST_LOW;
            end
            ST_LOW:
            begin
                state_next = at_or_below ? ST_RESULT : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (!step_down)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (md_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        hi_next        = hi_reg;
        x_next         = x_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    x_next   = in_x_value;
                    hi_next  = hi_top;
                    res_next = '0;
                end
            end
            ST_TOP:
            begin
                res_next = rd_data_reg.y;
                x1_next  = rd_data_reg.x;
                y1_next  = rd_data_reg.y;
            end
            ST_LOW:
            begin
                res_next = rd_data_reg.y;
            end
            ST_SEARCH:
            begin
                if (step_down)
                begin
                    x1_next = rd_data_reg.x;
                    y1_next = rd_data_reg.y;
                    hi_next = hi_reg - IW'(1);
                end
                else
                begin
                    x0_next = rd_data_reg.x;
                    y0_next = rd_data_reg.y;
                end
            end
            ST_START:
            begin
                res_next = res_reg;
            end
            ST_WAIT:
            begin
                if (md_done)
                begin
                    res_next = rising ? (y0_reg + md_d) : (y0_reg - md_d);
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            point_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                point_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg       <= hi_next;
        x_reg        <= x_next;
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        x1_reg       <= x1_next;
        y1_reg       <= y1_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* tb/sv/table_interp_unsigned_tb.sv */
`timescale 1ns / 1ps

module table_interp_unsigned_tb;

    import tiu_pkg::*;

    localparam int TBL_DEPTH = DEFAULT_MAX_POINTS;
    localparam int MAX_SHOWN = 10;
    localparam int PLAN_DEPTH = 32;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 80;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_WRITE,
        ROW_LOOKUP
    } row_op_t;

    typedef struct packed {
        row_op_t           op;
        logic [DATA_W-1:0] arg;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic              known;
        logic [DATA_W-1:0] y_known;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [PCOUNT_W-1:0]    cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [DATA_W-1:0]      m_axis_tdata;

    logic [DATA_W-1:0]      bp_x [0:TBL_DEPTH-1];
    logic [DATA_W-1:0]      bp_y [0:TBL_DEPTH-1];
    logic [PCOUNT_W-1:0]    pcount_model;
    logic [DATA_W-1:0]      y_pending_q [$];
    logic [DATA_W-1:0]      y_head;
    plan_row_t              plan [0:PLAN_DEPTH-1];
    int                     plan_len;
    int                     fail_cnt;
    int                     src_idle;
    int                     sink_idle;
    int                     ph;
    int                     k;
    int                     sel;
    int                     shape;
    int unsigned            n_act;
    logic [DATA_W-1:0]      xv;
    logic [DATA_W-1:0]      lo_x;
    logic [DATA_W-1:0]      hi_x;
    logic [DATA_W-1:0]      acc_x;
    logic [PCOUNT_W-1:0]    phase_cnt;

    table_interp_unsigned u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned points_in_use();
        return (pcount_model > TBL_DEPTH) ? TBL_DEPTH : pcount_model;
    endfunction

    function automatic logic [DATA_W-1:0] interp_y(input logic [DATA_W-1:0] xq);
        int unsigned     n;
        int unsigned     hi;
        longint unsigned x0;
        longint unsigned x1;
        longint unsigned y0;
        longint unsigned y1;
        longint unsigned frac;
        longint unsigned d;
        n = points_in_use();
        if (n == 0)
            return '0;
        hi = n - 1;
        if (xq >= bp_x[hi])
            return bp_y[hi];
        if (xq <= bp_x[0])
            return bp_y[0];
        while (hi > 1 && bp_x[hi-1] > xq)
            hi--;
        x0 = bp_x[hi-1];
        x1 = bp_x[hi];
        y0 = bp_y[hi-1];
        y1 = bp_y[hi];
        if (x1 <= x0)
            return y0[DATA_W-1:0];
        frac = (64'(FULL_SCALE) * (64'(xq) - x0)) / (x1 - x0) + 1;
        if (y0 < y1)
        begin
            d = (frac * (y1 - y0)) / 64'(FULL_SCALE);
            return DATA_W'(y0 + d);
        end
        d = (frac * (y0 - y1)) / 64'(FULL_SCALE);
        return DATA_W'(y0 - d);
    endfunction

    task automatic wait_drained();
        while (y_pending_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_point_count(input logic [PCOUNT_W-1:0] v);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en    = 1'b0;
        pcount_model = v;
    endtask

    task automatic send_item(input logic act, input logic [ENTRY_INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] ex, input logic [DATA_W-1:0] ey,
                             input logic [DATA_W-1:0] xq, input logic known,
                             input logic [DATA_W-1:0] y_known);
        while ($urandom_range(0, 99) < src_idle)
            @(negedge clk);
        s_axis_tuser  = act;
        s_axis_tdata  = {4'b0000, xq, ey, ex, idx};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (act == ACTION_LOOKUP)
            y_pending_q.push_back(known ? y_known : interp_y(xq));
        else
        begin
            bp_x[idx] = ex;
            bp_y[idx] = ey;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_write(input logic [ENTRY_INDEX_W-1:0] idx,
                              input logic [DATA_W-1:0] ex, input logic [DATA_W-1:0] ey);
        send_item(ACTION_WRITE, idx, ex, ey, DATA_W'($urandom), 1'b0, '0);
    endtask

    task automatic send_lookup(input logic [DATA_W-1:0] xq);
        send_item(ACTION_LOOKUP, ENTRY_INDEX_W'($urandom), DATA_W'($urandom),
                  DATA_W'($urandom), xq, 1'b0, '0);
    endtask

    task automatic add_row(input row_op_t op, input logic [DATA_W-1:0] arg,
                           input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                           input logic known, input logic [DATA_W-1:0] y_known);
        plan[plan_len] = '{op, arg, x, y, known, y_known};
        plan_len++;
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready = ($urandom_range(0, 99) >= sink_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (y_pending_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_SHOWN)
                    $display("unexpected item: y_value %h", m_axis_tdata);
            end
            else
            begin
                y_head = y_pending_q.pop_front();
                if (m_axis_tdata !== y_head)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_SHOWN)
                        $display("y_value mismatch: expected %h, got %h", y_head, m_axis_tdata);
                end
            end
        end
    end

    initial
    begin
        #6_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACTION_WRITE;
        pcount_model  = '0;
        fail_cnt      = 0;
        plan_len      = 0;
        src_idle      = 18;
        sink_idle     = 67;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // known table: ascending x, y swinging up and down
        for (k = 0; k < TBL_DEPTH; k++)
            send_write(ENTRY_INDEX_W'(k), DATA_W'(1000 + 4000 * k),
                       (k % 2) ? DATA_W'(16'hFFFF - 100 * k) : DATA_W'(50 * k));

        add_row(ROW_LOOKUP, 0, 16'h0000, 0, 1'b1, 16'h0000);
        add_row(ROW_LOOKUP, 0, 16'hFFFF, 0, 1'b1, 16'h0000);
        add_row(ROW_CFG,    1, 0,        0, 1'b0, 0);
        add_row(ROW_LOOKUP, 0, 16'h0000, 0, 1'b1, 16'h0000);
        add_row(ROW_LOOKUP, 0, 16'hFFFF, 0, 1'b1, 16'h0000);
        add_row(ROW_CFG,    16, 0,       0, 1'b0, 0);
        add_row(ROW_LOOKUP, 0, 16'h0000, 0, 1'b1, 16'h0000);
        add_row(ROW_LOOKUP, 0, 16'hFFFF, 0, 1'b1, 16'hFA23);
        add_row(ROW_LOOKUP, 0, 1000,     0, 1'b1, 16'h0000);
        add_row(ROW_LOOKUP, 0, 61000,    0, 1'b1, 16'hFA23);
        add_row(ROW_LOOKUP, 0, 1001,     0, 1'b0, 0);
        add_row(ROW_LOOKUP, 0, 4999,     0, 1'b0, 0);
        add_row(ROW_LOOKUP, 0, 5000,     0, 1'b0, 0);
        add_row(ROW_LOOKUP, 0, 33001,    0, 1'b0, 0);
        add_row(ROW_WRITE,  15, 16'hFFFF, 16'hFFFF, 1'b0, 0);
        add_row(ROW_LOOKUP, 0, 16'hFFFF, 0, 1'b1, 16'hFFFF);
        add_row(ROW_LOOKUP, 0, 16'hFFFE, 0, 1'b0, 0);
        add_row(ROW_WRITE,  0, 16'h0000, 16'h0000, 1'b0, 0);
        add_row(ROW_LOOKUP, 0, 16'h0000, 0, 1'b1, 16'h0000);
        add_row(ROW_CFG,    31, 0,       0, 1'b0, 0);
        add_row(ROW_LOOKUP, 0, 16'hFFFF, 0, 1'b1, 16'hFFFF);
        add_row(ROW_CFG,    17, 0,       0, 1'b0, 0);
        add_row(ROW_LOOKUP, 0, 16'h0000, 0, 1'b1, 16'h0000);
        // breakpoint out of order in the middle of the table
        add_row(ROW_WRITE,  7, 16'h0000, 1234, 1'b0, 0);
        add_row(ROW_LOOKUP, 0, 30000,    0, 1'b0, 0);
        add_row(ROW_CFG,    2, 0,        0, 1'b0, 0);
        add_row(ROW_LOOKUP, 0, 3000,     0, 1'b0, 0);

        for (k = 0; k < plan_len; k++)
        begin
            case (plan[k].op)
                ROW_CFG:    set_point_count(PCOUNT_W'(plan[k].arg));
                ROW_WRITE:  send_write(ENTRY_INDEX_W'(plan[k].arg), plan[k].x, plan[k].y);
                default:    send_item(ACTION_LOOKUP, ENTRY_INDEX_W'($urandom),
                                      DATA_W'($urandom), DATA_W'($urandom), plan[k].x,
                                      plan[k].known, plan[k].y_known);
            endcase
        end

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph < 3)
            begin
                src_idle  = 18;
                sink_idle = 67;
            end
            else if (ph < 6)
            begin
                src_idle  = 67;
                sink_idle = 18;
            end
            else
            begin
                src_idle  = 0;
                sink_idle = 0;
            end
            case (ph)
                0:       phase_cnt = 16;
                1:       phase_cnt = 2;
                2:       phase_cnt = 31;
                3:       phase_cnt = 1;
                4:       phase_cnt = 0;
                5:       phase_cnt = 17;
                6:       phase_cnt = PCOUNT_W'($urandom_range(3, 15));
                default: phase_cnt = 16;
            endcase
            set_point_count(phase_cnt);

            // fresh table: mostly ascending, sometimes tightly packed or shuffled
            shape = $urandom_range(0, 9);
            acc_x = DATA_W'($urandom_range(0, 4095));
            for (k = 0; k < TBL_DEPTH; k++)
            begin
                if (shape == 0)
                    acc_x = DATA_W'($urandom);
                else if (k > 0)
                    acc_x = acc_x + DATA_W'((shape == 1) ? $urandom_range(0, 3)
                                                         : $urandom_range(0, 4095));
                send_write(ENTRY_INDEX_W'(k), acc_x, DATA_W'($urandom));
            end

            n_act = points_in_use();
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2 || $urandom_range(0, 99) < 3)
                    wait_drained();
                if ($urandom_range(0, 99) < 12)
                    send_write(ENTRY_INDEX_W'($urandom_range(0, 15)), DATA_W'($urandom),
                               DATA_W'($urandom));
                else
                begin
                    lo_x = (n_act == 0) ? '0 : bp_x[0];
                    hi_x = (n_act == 0) ? '1 : bp_x[n_act-1];
                    sel  = $urandom_range(0, 99);
                    if (sel < 60)
                        xv = DATA_W'($urandom_range(lo_x, hi_x));
                    else if (sel < 75 && n_act != 0)
                        xv = bp_x[$urandom_range(0, n_act - 1)]
                             + DATA_W'($urandom_range(0, 2)) - 1'b1;
                    else if (sel < 90)
                        xv = DATA_W'($urandom);
                    else
                        xv = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    send_lookup(xv);
                end
            end
        end

        while (y_pending_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (fail_cnt == 0 && y_pending_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
